// ----- rtl/bmhpq_pkg.sv -----
// Shared types, sizes and codes for the binary max-heap priority queue.
// No dependencies; the sequencer, top level and checker import this package.
`default_nettype none

package bmhpq_pkg;

    localparam int CAPACITY       = 64;
    localparam int DATA_WIDTH     = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int IDX_W          = $clog2(CAPACITY);
    localparam int CNT_W          = $clog2(CAPACITY + 1);
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [DATA_WIDTH-1:0]     entry_data;
        logic [PRIORITY_WIDTH-1:0] entry_priority;
    } cmd_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]     front_data;
        logic [PRIORITY_WIDTH-1:0] front_priority;
        cnt_t                      entry_count;
        logic                      is_empty;
        logic [STATUS_W-1:0]       status;
    } result_t;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [DATA_WIDTH-1:0]     data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Memory port bundle from the sequencer to the entry store
    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/bmhpq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bmhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bmhpq_seq.sv -----
// Sift sequencer: walks the heap in the entry store one level at a time
// and produces the result of every transaction. Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_seq
    import bmhpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    output logic         busy,
    output logic         done,
    output result_t      result,
    output mem_req_t     mem_req,
    input  wire entry_t  mem_rdata
);

    localparam int CW = IDX_W + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_DN_LAST = 3'd2;
    localparam logic [2:0] S_DN_CHK  = 3'd3;
    localparam logic [2:0] S_DN_L    = 3'd4;
    localparam logic [2:0] S_DN_R    = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    logic [2:0]          state_reg,  state_next;
    cnt_t                count_reg,  count_next;
    idx_t                pos_reg,    pos_next;
    entry_t              elem_reg,   elem_next;
    entry_t              lch_reg,    lch_next;
    entry_t              front_reg,  front_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                done_reg,   done_next;
    result_t             result_reg, result_next;

    logic [CW-1:0] count_ext;
    logic [CW-1:0] left_w;
    logic [CW-1:0] right_w;
    idx_t          par_idx;
    idx_t          cnt_m1;
    entry_t        child;
    idx_t          child_idx;
    logic          decide;
    logic          emit;

    assign count_ext = {{(CW - CNT_W){1'b0}}, count_reg};
    assign left_w    = {1'b0, pos_reg, 1'b1};
    assign right_w   = left_w + CW'(1);
    assign par_idx   = idx_t'((pos_reg - idx_t'(1)) >> 1);
    assign cnt_m1    = idx_t'(count_reg - cnt_t'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        lch_next    = lch_reg;
        front_next  = front_reg;
        status_next = status_reg;
        emit        = 1'b0;
        decide      = 1'b0;
        child       = mem_rdata;
        child_idx   = left_w[IDX_W-1:0];
        mem_req     = '0;
        mem_req.wdata = elem_reg;
        mem_req.waddr = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = STATUS_OK;
                    priority if (cmd.mode == MODE_PUSH)
                    begin
                        if (count_reg == cnt_t'(CAPACITY))
                        begin
                            status_next = STATUS_PUSH_FULL;
                            emit        = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + cnt_t'(1);
                            pos_next   = idx_t'(count_reg);
                            elem_next  = '{prio: cmd.entry_priority, data: cmd.entry_data};
                            if (count_reg == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                // parent of the new slot
                                mem_req.raddr = idx_t'((count_reg - cnt_t'(1)) >> 1);
                                state_next    = S_UP;
                            end
                        end
                    end
                    else if (cmd.mode == MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_POP_EMPTY;
                            emit        = 1'b1;
                        end
                        else if (count_reg == cnt_t'(1))
                        begin
                            count_next = '0;
                            emit       = 1'b1;
                        end
                        else
                        begin
                            count_next    = count_reg - cnt_t'(1);
                            mem_req.raddr = cnt_m1;
                            state_next    = S_DN_LAST;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end

            S_UP:
            begin
                if (elem_reg.prio > mem_rdata.prio)
                begin
                    // move the parent down into the hole
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = mem_rdata;
                    pos_next      = par_idx;
                    if (par_idx == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_req.raddr = idx_t'((par_idx - idx_t'(1)) >> 1);
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DN_LAST:
            begin
                elem_next  = mem_rdata;
                pos_next   = '0;
                state_next = S_DN_CHK;
            end

            S_DN_CHK:
            begin
                if (left_w < count_ext)
                begin
                    mem_req.raddr = left_w[IDX_W-1:0];
                    state_next    = S_DN_L;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DN_L:
            begin
                lch_next = mem_rdata;
                if (right_w < count_ext)
                begin
                    mem_req.raddr = right_w[IDX_W-1:0];
                    state_next    = S_DN_R;
                end
                else
                begin
                    decide = 1'b1;
                end
            end

            S_DN_R:
            begin
                decide = 1'b1;
                if (lch_reg.prio > mem_rdata.prio)
                begin
                    child = lch_reg;
                end
                else
                begin
                    child     = mem_rdata;
                    child_idx = right_w[IDX_W-1:0];
                end
            end

            S_FIN:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = elem_reg;
                if (pos_reg == '0)
                begin
                    front_next = elem_reg;
                end
                emit       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // promote the bigger child into the hole, or settle the element
        if (decide)
        begin
            if (child.prio > elem_reg.prio)
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = child;
                if (pos_reg == '0)
                begin
                    front_next = child;
                end
                pos_next   = child_idx;
                state_next = S_DN_CHK;
            end
            else
            begin
                state_next = S_FIN;
            end
        end
    end

    always_comb
    begin
        done_next                  = emit;
        result_next.entry_count    = count_next;
        result_next.is_empty       = (count_next == '0);
        result_next.status         = status_next;
        result_next.front_data     = (count_next == '0) ? '0 : front_next.data;
        result_next.front_priority = (count_next == '0) ? '0 : front_next.prio;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        lch_reg    <= lch_next;
        front_reg  <= front_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/binary_max_heap_priority_queue_unit.sv -----
// Peek, mode 3, rejected push, rejected or single-entry pop: done in the cycle after start.
// Push sifts the new entry up; pop moves the last entry to the root and sifts it down.
// One transaction at a time: busy stays high until the cycle before done; the next start
// may come in the cycle done is shown. The sift walk over the single-read entry RAM paces each transaction.
// Reset clears the entry count and the sequencer; the entry RAM is not cleared.
// Top level of the heap queue: sequencer plus entry RAM. Depends on bmhpq_pkg.
`default_nettype none

module binary_max_heap_priority_queue_unit
    import bmhpq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t cmd,
    output logic      busy,
    output logic      done,
    output result_t   result
);

    mem_req_t mem_req;
    entry_t   mem_rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    bmhpq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bmhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata_raw)
    );

    assign mem_rdata = entry_t'(rdata_raw);

endmodule

`default_nettype wire

// ----- rtl/bmhpq_checker.sv -----
// Port-level checks for the heap queue top level, bound to it below.
// Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_checker
    import bmhpq_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire cmd_t    cmd,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // every accepted transaction either finishes next cycle or keeps the unit busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither busy nor done");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |->
            (result.front_data == '0 && result.front_priority == '0))
        else $error("front entry not zero on empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count <= CNT_W'(CAPACITY)
                  && result.status <= STATUS_POP_EMPTY))
        else $error("count or status out of range");

endmodule

bind binary_max_heap_priority_queue_unit bmhpq_checker u_bmhpq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
